### rtl/core/dtpt_pkg.sv
package dtpt_pkg;

    // Table geometry and value format.
    localparam int NUM_ENTRIES = 128;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int VAL_W       = FRAC_BITS + 1;
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int IN_IDX_W    = 10;
    localparam int IN_VAL_W    = 18;

    // The pending scan looks at one aligned group of bits per cycle.
    localparam int GRP_SIZE = 8;
    localparam int NUM_GRP  = NUM_ENTRIES / GRP_SIZE;
    localparam int OFS_W    = $clog2(GRP_SIZE);
    localparam int GRP_W    = $clog2(NUM_GRP);
    localparam int STEP_W   = $clog2(NUM_GRP + 1);

    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REQ_SET      = 3'd0,
        REQ_FORCE    = 3'd1,
        REQ_QUIET    = 3'd2,
        REQ_GET      = 3'd3,
        REQ_TAKE     = 3'd4,
        REQ_MARK_ALL = 3'd5
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    // Commands from the sequencer to the pending-bit tracker.
    typedef struct packed {
        logic             scan_start;
        logic             mark;
        logic             take;
        logic             mark_all;
        logic [IDX_W-1:0] idx;
    } t_pend_cmd;

    // Status from the pending-bit tracker.
    typedef struct packed {
        logic             busy;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
    } t_pend_stat;

endpackage

### rtl/core/dtpt_value_mem.sv
module dtpt_value_mem
    import dtpt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [VAL_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [VAL_W-1:0] i_wr_data
);

    logic [VAL_W-1:0]       mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_written;
    logic [VAL_W-1:0]       r_rd_data;
    logic                   r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

### rtl/core/dtpt_pending.sv
module dtpt_pending
    import dtpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pend_cmd  i_cmd,
    output t_pend_stat o_stat
);

    logic [NUM_ENTRIES-1:0] r_bits;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [IDX_W-1:0]       r_cursor;
    logic                   r_scan_on;
    logic [STEP_W-1:0]      r_step;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;

    logic [GRP_W-1:0]    grp;
    logic [OFS_W-1:0]    ofs;
    logic [GRP_SIZE-1:0] grp_bits;
    logic [GRP_SIZE-1:0] low_mask;
    logic [GRP_SIZE-1:0] mask;
    logic [GRP_SIZE-1:0] masked;
    logic                grp_hit;
    logic [OFS_W-1:0]    grp_pos;

    // The first step looks at the cursor's group from the cursor up, the middle
    // steps at whole groups, and the last step at the cursor's group below it.
    always_comb begin
        ofs      = r_cursor[OFS_W-1:0];
        grp      = r_cursor[IDX_W-1:OFS_W] + r_step[GRP_W-1:0];
        grp_bits = r_bits[{grp, {OFS_W{1'b0}}} +: GRP_SIZE];
        low_mask = (GRP_SIZE'(1) << ofs) - GRP_SIZE'(1);
        if (r_step == '0) begin
            mask = ~low_mask;
        end else if (r_step == STEP_W'(NUM_GRP)) begin
            mask = low_mask;
        end else begin
            mask = '1;
        end
        masked  = grp_bits & mask;
        grp_hit = |masked;
        grp_pos = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (masked[i]) begin
                grp_pos = OFS_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.mark_all) begin
            n_count = CNT_W'(NUM_ENTRIES);
        end else if (i_cmd.mark && !r_bits[i_cmd.idx]) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.take) begin
            n_count = r_hit ? r_count - CNT_W'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= '0;
            r_count   <= '0;
            r_cursor  <= '0;
            r_scan_on <= 1'b0;
            r_step    <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.mark_all) begin
                r_bits <= '1;
            end else if (i_cmd.mark) begin
                r_bits[i_cmd.idx] <= 1'b1;
            end else if (i_cmd.take && r_hit) begin
                r_bits[r_hit_idx] <= 1'b0;
                r_cursor <= (r_hit_idx == IDX_W'(NUM_ENTRIES - 1)) ?
                            '0 : r_hit_idx + IDX_W'(1);
            end
            if (i_cmd.take) begin
                r_hit <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_step    <= '0;
                r_hit     <= 1'b0;
            end else if (r_scan_on) begin
                if (grp_hit) begin
                    r_scan_on <= 1'b0;
                    r_hit     <= 1'b1;
                    r_hit_idx <= {grp, grp_pos};
                end else if (r_step == STEP_W'(NUM_GRP)) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end
        end
    end

    assign o_stat.busy       = r_scan_on;
    assign o_stat.hit        = r_hit;
    assign o_stat.hit_idx    = r_hit_idx;
    assign o_stat.count      = r_count;
    assign o_stat.count_next = n_count;

`ifndef SYNTHESIS
    a_count_matches_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_bits) == int'(r_count))
        else $error("pending count out of step with pending bits");

    a_no_restart_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_on |-> !i_cmd.scan_start)
        else $error("scan restarted while a scan is running");

    a_hit_is_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && !r_scan_on) |-> r_bits[r_hit_idx])
        else $error("scan reported an entry that is not pending");
`endif

endmodule

### rtl/core/dirty_tracked_param_table.sv
// An accepted request moves to the execute state, after a scan state for a take with
// entries pending (eight bits per step); its result is then registered at the output.
// Only one request is in flight: the next is accepted only once the last result has
// been committed to the output register, so an output stall also holds the input.
// Reset (i_rst_n, synchronous, active low) empties the table:
// all values read as zero, no entry pending, count and cursor zero.
module dirty_tracked_param_table
    import dtpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, lowest bit first: param_index[9:0], new_value[27:10], zero pad[31:28]
    input  logic [31:0] s_axis_tdata,
    // tuser, lowest bit first: req_type[2:0], value_invalid[3]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, lowest bit first: done_ok[0], read_value[17:1], taken_index[24:18],
    // none_pending[25], pending_count[33:26], zero pad[39:34]
    output logic [39:0] m_axis_tdata
);

    t_state r_state;
    t_state n_state;

    // The request being served, captured when it is accepted.
    t_req_kind        r_kind;
    logic [IDX_W-1:0] r_idx;
    logic             r_in_range;
    logic             r_invalid;
    logic [VAL_W-1:0] r_value;

    // Output register: the next request can be accepted while a result waits here.
    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic                   accept;
    logic                   out_free;
    logic                   commit;
    t_req_kind              in_kind;
    logic [IN_IDX_W-1:0]    in_idx;
    logic [IN_VAL_W-1:0]    in_val;
    logic [VAL_W-1:0]       in_clamped;
    logic                   take_scan;
    logic [VAL_W-1:0]       rd_data;
    logic                   is_set;
    logic                   do_write;
    t_pend_cmd              pend_cmd;
    t_pend_stat             pend_stat;
    logic                   res_ok;
    logic [VAL_W-1:0]       res_read;
    logic [IDX_W-1:0]       res_taken;
    logic                   res_none;

    assign in_kind  = t_req_kind'(s_axis_tuser[2:0]);
    assign in_idx   = s_axis_tdata[IN_IDX_W-1:0];
    assign in_val   = s_axis_tdata[IN_IDX_W +: IN_VAL_W];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Clamp the signed input to 0..1.0 before it is compared and stored.
    always_comb begin
        if (in_val[IN_VAL_W-1]) begin
            in_clamped = '0;
        end else if (in_val[IN_VAL_W-2:0] > VAL_ONE) begin
            in_clamped = VAL_ONE;
        end else begin
            in_clamped = in_val[VAL_W-1:0];
        end
    end

    // A take only scans when the count says something is pending.
    assign take_scan = (in_kind == REQ_TAKE) && (pend_stat.count != '0);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = take_scan ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                if (!pend_stat.busy) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State-machine outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: ;
            ST_EXEC: commit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= in_kind;
            r_idx      <= in_idx[IDX_W-1:0];
            r_in_range <= (in_idx < IN_IDX_W'(NUM_ENTRIES));
            r_invalid  <= s_axis_tuser[3];
            r_value    <= in_clamped;
        end
    end

    // The entry is read on acceptance; its data is ready in the execute cycle,
    // where it is compared and, for a set, written back. Only one request is in
    // flight, so a read never meets a pending write to the same entry.
    dtpt_value_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (in_idx[IDX_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (commit && do_write),
        .i_wr_addr (r_idx),
        .i_wr_data (r_value)
    );

    // A valid in-range set writes: plain or quiet only on a change, forced always.
    always_comb begin
        is_set = 1'b0;
        case (r_kind)
            REQ_SET, REQ_FORCE, REQ_QUIET: is_set = 1'b1;
            default: is_set = 1'b0;
        endcase
        do_write = is_set && r_in_range && !r_invalid &&
                   ((r_kind == REQ_FORCE) || (rd_data != r_value));
    end

    always_comb begin
        pend_cmd.scan_start = accept && take_scan;
        pend_cmd.mark       = commit && do_write && (r_kind != REQ_QUIET);
        pend_cmd.take       = commit && (r_kind == REQ_TAKE);
        pend_cmd.mark_all   = commit && (r_kind == REQ_MARK_ALL);
        pend_cmd.idx        = r_idx;
    end

    dtpt_pending u_pending (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pend_cmd),
        .o_stat  (pend_stat)
    );

    // Result fields; unused request kinds carry only the pending count.
    always_comb begin
        res_ok    = 1'b0;
        res_read  = '0;
        res_taken = '0;
        res_none  = 1'b0;
        case (r_kind)
            REQ_SET, REQ_FORCE, REQ_QUIET: begin
                res_ok = do_write;
            end
            REQ_GET: begin
                res_read = r_in_range ? rd_data : '0;
            end
            REQ_TAKE: begin
                res_ok    = pend_stat.hit;
                res_none  = !pend_stat.hit;
                res_taken = pend_stat.hit ? pend_stat.hit_idx : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {6'b0, pend_stat.count_next, res_none, res_taken,
                           res_read, res_ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted request did not start execution");

    a_write_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && do_write) |-> (r_in_range && !r_invalid && is_set))
        else $error("table written by a request that must not write");

    a_exec_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !m_axis_tready) |=>
        (r_state == ST_EXEC && $stable(r_out_data)))
        else $error("result committed over a waiting result");
`endif

endmodule

### tb/dirty_tracked_param_table_test.sv
module dirty_tracked_param_table_test;
    import dtpt_pkg::*;

    // Request codes 6 and 7 are not decoded by the block; they must pass
    // through with only the pending count reported.
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    localparam int DIRECTED_LEN  = 25;
    localparam int PHASE_ITEMS   = 457;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RUN_LIMIT     = 5_000_000;

    // One reply, laid out so that it unpacks straight from the result tdata
    // (done_ok in the lowest bit).
    typedef struct packed {
        logic [CNT_W-1:0] pending_count;
        logic             none_pending;
        logic [IDX_W-1:0] taken_index;
        logic [VAL_W-1:0] read_value;
        logic             done_ok;
    } reply_t;

    // One row of the directed plan. Where typed is set, want is the reply
    // written out by hand; elsewhere the reply comes from the shadow table.
    typedef struct {
        logic [2:0]                 kind;
        logic [IN_IDX_W-1:0]        idx;
        logic signed [IN_VAL_W-1:0] val;
        logic                       inv;
        bit                         typed;
        reply_t                     want;
    } step_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata, lowest bit first: param_index[9:0], new_value[27:10], zero pad[31:28]
    logic [31:0] s_axis_tdata;
    // tuser, lowest bit first: req_type[2:0], value_invalid[3]
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata, lowest bit first: done_ok[0], read_value[17:1], taken_index[24:18],
    // none_pending[25], pending_count[33:26], zero pad[39:34]
    logic [39:0] m_axis_tdata;

    // Shadow copy of the table state.
    logic [VAL_W-1:0] shadow_value [NUM_ENTRIES];
    bit               shadow_pending [NUM_ENTRIES];
    int               shadow_count;
    int               shadow_cursor;

    reply_t awaited_replies [$];
    int     err_count    = 0;
    int     results_seen = 0;
    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;

    // Reply order in want: {pending_count, none_pending, taken_index, read_value, done_ok}.
    step_t directed_plan [DIRECTED_LEN] = '{
        // Empty table: get reads zero, take finds nothing.
        '{REQ_GET,      10'd0,    18'sd0,       1'b0, 1'b1, '{8'd0, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_TAKE,     10'd0,    18'sd0,       1'b0, 1'b1, '{8'd0, 1'b1, 7'd0, 17'd0, 1'b0}},
        // Same value as stored: a plain set does nothing.
        '{REQ_SET,      10'd0,    18'sd0,       1'b0, 1'b1, '{8'd0, 1'b0, 7'd0, 17'd0, 1'b0}},
        // Largest input clamps to 1.0 at the top entry.
        '{REQ_SET,      10'd127,  18'sd131071,  1'b0, 1'b1, '{8'd1, 1'b0, 7'd0, 17'd0, 1'b1}},
        '{REQ_GET,      10'd127,  18'sd0,       1'b0, 1'b1, '{8'd1, 1'b0, 7'd0, 17'd65536, 1'b0}},
        // Most negative input clamps to zero, which is already stored.
        '{REQ_SET,      10'd5,    -18'sd131072, 1'b0, 1'b1, '{8'd1, 1'b0, 7'd0, 17'd0, 1'b0}},
        // A forced set succeeds and marks even with no change.
        '{REQ_FORCE,    10'd5,    -18'sd1,      1'b0, 1'b1, '{8'd2, 1'b0, 7'd0, 17'd0, 1'b1}},
        '{REQ_QUIET,    10'd9,    18'sd32768,   1'b0, 1'b0, '0},
        // Index out of range and not-a-number values are rejected.
        '{REQ_SET,      10'd128,  18'sd100,     1'b0, 1'b1, '{8'd2, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_FORCE,    10'd1023, 18'sd100,     1'b0, 1'b1, '{8'd2, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_SET,      10'd3,    18'sd1000,    1'b1, 1'b1, '{8'd2, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_QUIET,    10'd9,    18'sd32768,   1'b0, 1'b0, '0},
        '{REQ_GET,      10'd1023, 18'sd0,       1'b0, 1'b1, '{8'd2, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_GET,      10'd9,    18'sd0,       1'b0, 1'b0, '0},
        // Drain both pending entries; the second take wraps the cursor.
        '{REQ_TAKE,     10'd0,    18'sd0,       1'b0, 1'b0, '0},
        '{REQ_TAKE,     10'd0,    18'sd0,       1'b0, 1'b0, '0},
        '{REQ_TAKE,     10'd0,    18'sd0,       1'b0, 1'b1, '{8'd0, 1'b1, 7'd0, 17'd0, 1'b0}},
        // Unused codes carry only the count.
        '{REQ_SPARE6,   10'd1023, 18'sd131071,  1'b1, 1'b1, '{8'd0, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_SPARE7,   10'd0,    -18'sd131072, 1'b0, 1'b1, '{8'd0, 1'b0, 7'd0, 17'd0, 1'b0}},
        // Mark-all fills the table; a second one counts nothing twice.
        '{REQ_MARK_ALL, 10'd0,    18'sd0,       1'b0, 1'b1, '{8'd128, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_MARK_ALL, 10'd1023, 18'sd0,       1'b0, 1'b1, '{8'd128, 1'b0, 7'd0, 17'd0, 1'b0}},
        '{REQ_SET,      10'd1,    18'sd65537,   1'b0, 1'b0, '0},
        '{REQ_TAKE,     10'd0,    18'sd0,       1'b0, 1'b0, '0},
        '{REQ_FORCE,    10'd0,    18'sd65536,   1'b0, 1'b0, '0},
        '{REQ_QUIET,    10'd127,  18'sd12345,   1'b0, 1'b0, '0}
    };

    dirty_tracked_param_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the reply it causes.
    function automatic reply_t table_response(input logic [2:0] kind,
                                              input logic [IN_IDX_W-1:0] idx,
                                              input logic signed [IN_VAL_W-1:0] val,
                                              input logic inv);
        reply_t r;
        int     v;
        int     o;
        bit     found;
        r = '0;
        found = 1'b0;
        case (kind)
            REQ_SET, REQ_FORCE, REQ_QUIET: begin
                if (idx < NUM_ENTRIES && !inv) begin
                    // Clamp to 0..1.0 before the compare.
                    v = int'(val);
                    if (v < 0) v = 0;
                    if (v > int'(VAL_ONE)) v = int'(VAL_ONE);
                    if (kind == REQ_FORCE || shadow_value[idx] != v[VAL_W-1:0]) begin
                        shadow_value[idx] = v[VAL_W-1:0];
                        if (kind != REQ_QUIET && !shadow_pending[idx]) begin
                            shadow_pending[idx] = 1'b1;
                            shadow_count++;
                        end
                        r.done_ok = 1'b1;
                    end
                end
            end
            REQ_GET: begin
                if (idx < NUM_ENTRIES) r.read_value = shadow_value[idx];
            end
            REQ_TAKE: begin
                if (shadow_count != 0) begin
                    for (int i = 0; i < NUM_ENTRIES && !found; i++) begin
                        o = (shadow_cursor + i) % NUM_ENTRIES;
                        if (shadow_pending[o]) begin
                            shadow_pending[o] = 1'b0;
                            shadow_count--;
                            shadow_cursor = (o + 1) % NUM_ENTRIES;
                            r.taken_index = o[IDX_W-1:0];
                            found = 1'b1;
                        end
                    end
                    // A count with no pending bit behind it is dropped.
                    if (!found) shadow_count = 0;
                end
                r.done_ok = found;
                r.none_pending = !found;
            end
            REQ_MARK_ALL: begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!shadow_pending[i]) begin
                        shadow_pending[i] = 1'b1;
                        shadow_count++;
                    end
                end
            end
            default: ;
        endcase
        r.pending_count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // Offer one request, wait for it to be accepted, then queue its reply.
    // The sender may idle for a few cycles first, as the current phase asks.
    task automatic offer_request(input logic [2:0] kind, input logic [IN_IDX_W-1:0] idx,
                                 input logic signed [IN_VAL_W-1:0] val, input logic inv,
                                 input bit typed, input reply_t want);
        reply_t predicted;
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, val, idx};
        s_axis_tuser  <= {inv, kind};
        do @(posedge i_clk); while (!s_axis_tready);
        // The shadow state always advances; a hand-written reply replaces
        // the predicted one where the row gives it.
        predicted = table_response(kind, idx, val, inv);
        awaited_replies.push_back(typed ? want : predicted);
    endtask

    task automatic compare_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $display("%0t: reply %0d %s expected %0d got %0d",
                     $time, results_seen, name, exp, act);
            err_count++;
        end
    endtask

    // Reply checker: every accepted reply is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        reply_t want;
        reply_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = reply_t'(m_axis_tdata[$bits(reply_t)-1:0]);
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, m_axis_tdata);
                err_count++;
            end else begin
                want = awaited_replies.pop_front();
                compare_field("done_ok", want.done_ok, got.done_ok);
                compare_field("read_value", want.read_value, got.read_value);
                compare_field("taken_index", want.taken_index, got.taken_index);
                compare_field("none_pending", want.none_pending, got.none_pending);
                compare_field("pending_count", want.pending_count, got.pending_count);
            end
            results_seen++;
        end
    end

    // Reply side. Once the directed replies are in, the receiver holds off
    // for a long stretch while the sender keeps offering, so the block backs
    // up and stalls its input. After that it stalls at the phase's rate.
    initial begin
        int hold;
        bit held_once;
        held_once = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && !held_once && results_seen >= DIRECTED_LEN) begin
                held_once = 1'b1;
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge i_clk);
            end
            m_axis_tready <= !i_rst_n ? 1'b0 :
                             (rx_stall_pct == 0 || $urandom_range(99) >= rx_stall_pct);
        end
    end

    // Request side: reset, the directed plan, then four random phases with
    // different idling on each side.
    initial begin
        int phase_tx [4];
        int phase_rx [4];
        logic [2:0]                 kind;
        logic [IN_IDX_W-1:0]        idx;
        logic signed [IN_VAL_W-1:0] val;
        logic                       inv;
        int                         pick;

        phase_tx = '{0, 48, 0, 12};
        phase_rx = '{0, 0, 48, 12};
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            shadow_value[i] = '0;
            shadow_pending[i] = 1'b0;
        end
        shadow_count  = 0;
        shadow_cursor = 0;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[n])
            offer_request(directed_plan[n].kind, directed_plan[n].idx, directed_plan[n].val,
                          directed_plan[n].inv, directed_plan[n].typed, directed_plan[n].want);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 30)      kind = REQ_SET;
                else if (pick < 40) kind = REQ_FORCE;
                else if (pick < 50) kind = REQ_QUIET;
                else if (pick < 68) kind = REQ_GET;
                else if (pick < 95) kind = REQ_TAKE;
                else if (pick < 97) kind = REQ_MARK_ALL;
                else                kind = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;

                // Indices mostly land in the table, often in a few hot
                // entries so that repeated values hit the no-change path.
                pick = $urandom_range(99);
                if (pick < 30)      idx = IN_IDX_W'($urandom_range(7));
                else if (pick < 85) idx = IN_IDX_W'($urandom_range(NUM_ENTRIES - 1));
                else                idx = IN_IDX_W'($urandom_range(1023));

                // Values: a few favorites, in-range values, and raw noise that
                // covers every input bit and both clamp edges.
                pick = $urandom_range(99);
                if (pick < 40) begin
                    case ($urandom_range(3))
                        0:       val = '0;
                        1:       val = IN_VAL_W'(int'(VAL_ONE));
                        2:       val = IN_VAL_W'(int'(VAL_ONE) / 2);
                        default: val = IN_VAL_W'($urandom_range(3));
                    endcase
                end else if (pick < 80) begin
                    val = IN_VAL_W'($urandom_range(int'(VAL_ONE)));
                end else begin
                    val = IN_VAL_W'($urandom);
                end
                inv = ($urandom_range(99) < 5);

                offer_request(kind, idx, val, inv, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (awaited_replies.size() == 0);
        // Let any stray reply surface before deciding.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/core/dtpt_pkg.sv
rtl/core/dtpt_value_mem.sv
rtl/core/dtpt_pending.sv
rtl/core/dirty_tracked_param_table.sv
tb/dirty_tracked_param_table_test.sv
